>>> rtl/core/poc_pkg.sv
`timescale 1ns / 1ps

package poc_pkg;

    // Largest permutation length held in the parent stores.
    localparam int NODE_MAX   = 64;
    localparam int ADDR_W     = $clog2(NODE_MAX);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int GENE_W     = 6;
    localparam int GENE_SPACE = 1 << GENE_W;

    // Input tdata layout, lowest field first.
    localparam int IN_A_LSB   = 0;
    localparam int IN_B_LSB   = IN_A_LSB + GENE_W;
    localparam int IN_CS_LSB  = IN_B_LSB + GENE_W;
    localparam int IN_CS_W    = 6;
    localparam int IN_CE_LSB  = IN_CS_LSB + IN_CS_W;
    localparam int IN_CE_W    = 7;
    localparam int IN_EN_LSB  = IN_CE_LSB + IN_CE_W;
    localparam int IN_W       = 32;
    localparam int OUT_W      = 8;
    localparam int CFG_W      = 7;

    typedef enum logic [1:0] {
        S_LOAD,
        S_MARK,
        S_ISSUE,
        S_DATA
    } t_state;

    typedef enum logic [1:0] {
        SRC_A,
        SRC_B,
        SRC_WALK,
        SRC_ZERO
    } t_src;

endpackage

>>> rtl/core/poc_ram.sv
`timescale 1ns / 1ps

module poc_ram #(
    parameter int DATA_W = 6,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [0:(1 << ADDR_W)-1];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/permutation_order_crossover_top.sv
`timescale 1ns / 1ps

// Linear order crossover of two permutations of n genes, n being the node
// count register clamped into 1..64. Each input transaction carries one
// position of both parents; the cut points and the crossover enable are
// taken from the first transaction of a run and clamped into range. Loading
// accepts one position per cycle while the input is valid. With crossover
// on, the middle segment of parent B is then marked in a gene mask at one
// position per cycle over the clamped range cut_start to cut_end - 1. The
// child is emitted in position order: every output gene takes one parent
// store read and one step to check and register it, each gene of parent A
// that the walk skips takes another read and check, and the output stalls
// while the receiver holds off. The run time is set by the one read port of
// each parent store. The first transaction of the next run is accepted
// while the final child gene still waits at the output.
module permutation_order_crossover_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Configuration: node_count.
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [poc_pkg::CFG_W-1:0]  i_cfg_data,
    // tdata: parent_a_gene[5:0], parent_b_gene[11:6], cut_start[17:12],
    // cut_end[24:18], cross_enable[25], zero fill[31:26].
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [poc_pkg::IN_W-1:0]   i_s_tdata,
    // tdata: child_gene[5:0], zero fill[7:6].
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [poc_pkg::OUT_W-1:0]  o_m_tdata,
    output logic                       o_m_tlast
);

    localparam int AW = poc_pkg::ADDR_W;
    localparam int CW = poc_pkg::CNT_W;
    localparam int GW = poc_pkg::GENE_W;

    poc_pkg::t_state r_state, n_state;
    poc_pkg::t_src   r_src, n_src;

    logic [CW-1:0]   r_node_count;
    logic [CW-1:0]   r_load_idx, n_load_idx;
    logic [AW-1:0]   r_cut_lo, n_cut_lo;
    logic [CW-1:0]   r_cut_hi, n_cut_hi;
    logic            r_cross, n_cross;
    logic [AW-1:0]   r_mp, n_mp;
    logic            r_mpend, n_mpend;
    logic [AW-1:0]   r_p, n_p;
    logic [CW-1:0]   r_wp, n_wp;
    logic [poc_pkg::GENE_SPACE-1:0] r_skip, n_skip;
    logic            r_out_valid, n_out_valid;
    logic [GW-1:0]   r_out_gene, n_out_gene;
    logic            r_out_last, n_out_last;

    logic [CW-1:0]   eff_n;
    logic            in_acc;
    logic            first_item;
    logic            load_done;
    logic [CW-1:0]   cs_in, cs_clamp, ce_in, ce_lo, ce_clamp;
    logic            cross_now;
    logic [AW-1:0]   cut_lo_now;
    logic            mark_done;
    logic            in_middle;
    logic            slot_free;
    logic            skip_hit;
    logic            last_pos;
    logic [GW-1:0]   data_gene;

    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic            a_rd_en, b_rd_en;
    logic [AW-1:0]   a_rd_addr, b_rd_addr;
    logic [GW-1:0]   a_rd_data, b_rd_data;

    poc_ram #(.DATA_W(GW), .ADDR_W(AW)) u_store_a (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_s_tdata[poc_pkg::IN_A_LSB +: GW]),
        .i_rd_en   (a_rd_en),
        .i_rd_addr (a_rd_addr),
        .o_rd_data (a_rd_data)
    );

    poc_ram #(.DATA_W(GW), .ADDR_W(AW)) u_store_b (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_s_tdata[poc_pkg::IN_B_LSB +: GW]),
        .i_rd_en   (b_rd_en),
        .i_rd_addr (b_rd_addr),
        .o_rd_data (b_rd_data)
    );

    // Effective length: zero counts as one, anything above the store depth
    // counts as the depth.
    always_comb begin
        if (r_node_count == '0) begin
            eff_n = CW'(1);
        end else if (r_node_count > CW'(poc_pkg::NODE_MAX)) begin
            eff_n = CW'(poc_pkg::NODE_MAX);
        end else begin
            eff_n = r_node_count;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == poc_pkg::S_LOAD);
    assign in_acc      = i_s_tvalid && o_s_tready;
    assign first_item  = (r_load_idx == '0);
    assign load_done   = ((r_load_idx + CW'(1)) >= eff_n);

    // Cut clamping on the first item of a run.
    assign cs_in    = CW'(i_s_tdata[poc_pkg::IN_CS_LSB +: poc_pkg::IN_CS_W]);
    assign ce_in    = CW'(i_s_tdata[poc_pkg::IN_CE_LSB +: poc_pkg::IN_CE_W]);
    assign cs_clamp = (cs_in > (eff_n - CW'(1))) ? (eff_n - CW'(1)) : cs_in;
    assign ce_lo    = (ce_in < (cs_clamp + CW'(1))) ? (cs_clamp + CW'(1)) : ce_in;
    assign ce_clamp = (ce_lo > eff_n) ? eff_n : ce_lo;

    assign cross_now  = first_item ? i_s_tdata[poc_pkg::IN_EN_LSB] : r_cross;
    assign cut_lo_now = first_item ? cs_clamp[AW-1:0] : r_cut_lo;

    assign mark_done = ((CW'(r_mp) + CW'(1)) == r_cut_hi);
    assign in_middle = (r_p >= r_cut_lo) && (CW'(r_p) < r_cut_hi);
    assign slot_free = !r_out_valid || i_m_tready;
    assign last_pos  = ((CW'(r_p) + CW'(1)) == eff_n);

    always_comb begin
        case (r_src)
            poc_pkg::SRC_A:    data_gene = a_rd_data;
            poc_pkg::SRC_B:    data_gene = b_rd_data;
            poc_pkg::SRC_WALK: data_gene = a_rd_data;
            poc_pkg::SRC_ZERO: data_gene = '0;
            default:           data_gene = '0;
        endcase
    end

    assign skip_hit = (r_src == poc_pkg::SRC_WALK) && r_skip[a_rd_data];

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            poc_pkg::S_LOAD: begin
                if (in_acc && load_done) begin
                    n_state = cross_now ? poc_pkg::S_MARK : poc_pkg::S_ISSUE;
                end
            end
            poc_pkg::S_MARK: begin
                if (mark_done) begin
                    n_state = poc_pkg::S_ISSUE;
                end
            end
            poc_pkg::S_ISSUE: begin
                n_state = poc_pkg::S_DATA;
            end
            poc_pkg::S_DATA: begin
                if (skip_hit) begin
                    n_state = poc_pkg::S_ISSUE;
                end else if (slot_free) begin
                    n_state = last_pos ? poc_pkg::S_LOAD : poc_pkg::S_ISSUE;
                end
            end
            default: begin
                n_state = poc_pkg::S_LOAD;
            end
        endcase
    end

    // Datapath and memory controls.
    always_comb begin
        n_load_idx  = r_load_idx;
        n_cut_lo    = r_cut_lo;
        n_cut_hi    = r_cut_hi;
        n_cross     = r_cross;
        n_mp        = r_mp;
        n_mpend     = 1'b0;
        n_p         = r_p;
        n_wp        = r_wp;
        n_src       = r_src;
        n_skip      = r_skip;
        n_out_valid = r_out_valid;
        n_out_gene  = r_out_gene;
        n_out_last  = r_out_last;
        wr_en       = 1'b0;
        wr_addr     = r_load_idx[AW-1:0];
        a_rd_en     = 1'b0;
        a_rd_addr   = r_p;
        b_rd_en     = 1'b0;
        b_rd_addr   = r_p;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        // A segment gene read in the previous cycle lands in the mask now.
        if (r_mpend) begin
            n_skip[b_rd_data] = 1'b1;
        end

        case (r_state)
            poc_pkg::S_LOAD: begin
                if (in_acc) begin
                    wr_en = 1'b1;
                    if (first_item) begin
                        n_cut_lo = cs_clamp[AW-1:0];
                        n_cut_hi = ce_clamp;
                        n_cross  = i_s_tdata[poc_pkg::IN_EN_LSB];
                    end
                    if (load_done) begin
                        n_load_idx = '0;
                        n_p        = '0;
                        n_wp       = '0;
                        n_mp       = cut_lo_now;
                    end else begin
                        n_load_idx = r_load_idx + CW'(1);
                    end
                end
            end
            poc_pkg::S_MARK: begin
                b_rd_en   = 1'b1;
                b_rd_addr = r_mp;
                n_mpend   = 1'b1;
                n_mp      = r_mp + AW'(1);
            end
            poc_pkg::S_ISSUE: begin
                if (!r_cross) begin
                    a_rd_en   = 1'b1;
                    a_rd_addr = r_p;
                    n_src     = poc_pkg::SRC_A;
                end else if (in_middle) begin
                    b_rd_en   = 1'b1;
                    b_rd_addr = r_p;
                    n_src     = poc_pkg::SRC_B;
                end else if (r_wp < eff_n) begin
                    a_rd_en   = 1'b1;
                    a_rd_addr = r_wp[AW-1:0];
                    n_wp      = r_wp + CW'(1);
                    n_src     = poc_pkg::SRC_WALK;
                end else begin
                    // Walk ran out of parent A genes: pad with gene zero.
                    n_src     = poc_pkg::SRC_ZERO;
                end
            end
            poc_pkg::S_DATA: begin
                if (!skip_hit && slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_gene  = data_gene;
                    n_out_last  = last_pos;
                    n_p         = r_p + AW'(1);
                    if (last_pos) begin
                        n_skip = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= poc_pkg::S_LOAD;
            r_node_count <= CW'(poc_pkg::NODE_MAX);
            r_load_idx   <= '0;
            r_cut_lo     <= '0;
            r_cut_hi     <= CW'(1);
            r_cross      <= 1'b0;
            r_mp         <= '0;
            r_mpend      <= 1'b0;
            r_p          <= '0;
            r_wp         <= '0;
            r_src        <= poc_pkg::SRC_A;
            r_skip       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_node_count <= i_cfg_data;
            end
            r_load_idx   <= n_load_idx;
            r_cut_lo     <= n_cut_lo;
            r_cut_hi     <= n_cut_hi;
            r_cross      <= n_cross;
            r_mp         <= n_mp;
            r_mpend      <= n_mpend;
            r_p          <= n_p;
            r_wp         <= n_wp;
            r_src        <= n_src;
            r_skip       <= n_skip;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_gene <= n_out_gene;
        r_out_last <= n_out_last;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = poc_pkg::OUT_W'(r_out_gene);
    assign o_m_tlast  = r_out_last;

    // A pending mask update only follows a segment read, so it never
    // overlaps loading or a walk check.
    a_mark_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mpend |-> (r_state == poc_pkg::S_MARK || r_state == poc_pkg::S_ISSUE))
        else $error("mask update pending outside the mark phase");

    // Emission never runs past the effective length.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == poc_pkg::S_ISSUE || r_state == poc_pkg::S_DATA)
            |-> (CW'(r_p) < eff_n))
        else $error("child position beyond length");

    // A walked gene implies the walk pointer has moved past it.
    a_walk_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == poc_pkg::S_DATA && r_src == poc_pkg::SRC_WALK)
            |-> (r_wp != '0) && (r_wp <= eff_n))
        else $error("walk pointer inconsistent with walked gene");

    // The final child gene leaves the mask clear for the next run.
    a_mask_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == poc_pkg::S_DATA && !skip_hit && slot_free && last_pos)
            |=> (r_skip == '0) && (r_state == poc_pkg::S_LOAD) && o_m_tlast)
        else $error("run did not finish cleanly");

endmodule
